// ===== src/nnfc_pkg.sv =====
package nnfc_pkg;

  localparam int ACTUATORS  = 256;
  localparam int MAX_NEAR   = 8;
  localparam int FORCE_BITS = 24;

  localparam int ACT_W     = 8;
  localparam int SLOT_W    = 3;
  localparam int NB_W      = 8;
  localparam int FREQ_W    = 24;
  localparam int COUNT_W   = 4;
  localparam int LIMIT_W   = 23;
  localparam int EXCESS_W  = 28;

  localparam int AIDX_W     = $clog2(ACTUATORS);
  localparam int NB_IDX_W   = $clog2(MAX_NEAR);
  localparam int NB_ADDR_W  = AIDX_W + NB_IDX_W;
  localparam int CNTS_W     = $clog2(MAX_NEAR + 1);
  localparam int SUM_W      = FORCE_BITS + NB_IDX_W + 1;
  localparam int PROD_W     = FORCE_BITS + CNTS_W + 1;
  localparam int LIM_PROD_W = LIMIT_W + CNTS_W;
  localparam int DIFF_W     = PROD_W + 1;

  localparam logic [63:0] EXCESS_MAX = (64'd1 << EXCESS_W) - 64'd1;

  localparam logic [1:0] CMD_FORCE    = 2'd0;
  localparam logic [1:0] CMD_NEIGHBOR = 2'd1;
  localparam logic [1:0] CMD_COUNT    = 2'd2;
  localparam logic [1:0] CMD_CHECK    = 2'd3;

  typedef struct packed {
    logic [1:0]               command;
    logic [ACT_W-1:0]         actuator;
    logic [SLOT_W-1:0]        slot;
    logic [NB_W-1:0]          neighbor;
    logic signed [FREQ_W-1:0] force_req;
    logic [COUNT_W-1:0]       count;
    logic                     disabled;
    logic                     start_pass;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]    actuator_res;
    logic                warning;
    logic                skipped;
    logic [EXCESS_W-1:0] excess;
    logic                any_warning;
  } out_item_t;

  typedef struct packed {
    logic [CNTS_W-1:0] count;
    logic              disabled;
    logic              warn;
  } stat_t;

  typedef struct packed {
    logic signed [FORCE_BITS-1:0] force_val;
    stat_t                        stat;
  } act_entry_t;

  typedef struct packed {
    logic              force_en;
    logic              stat_en;
    logic [AIDX_W-1:0] addr;
    act_entry_t        entry;
  } act_wr_t;

  typedef struct packed {
    logic                 en;
    logic [NB_ADDR_W-1:0] addr;
    logic [NB_W-1:0]      data;
  } nb_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENTRY,
    S_SUM,
    S_MUL,
    S_CMP,
    S_DONE
  } seq_state_t;

endpackage

// ===== src/nnfc_act_mem.sv =====
module nnfc_act_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [nnfc_pkg::AIDX_W-1:0]   rd_addr,
  output nnfc_pkg::act_entry_t          rd_data,
  input  nnfc_pkg::act_wr_t             wr
);

  logic signed [nnfc_pkg::FORCE_BITS-1:0] force_mem [nnfc_pkg::ACTUATORS];
  nnfc_pkg::stat_t                        stat_mem  [nnfc_pkg::ACTUATORS];
  logic                                   stat_vld_r [nnfc_pkg::ACTUATORS];

  logic signed [nnfc_pkg::FORCE_BITS-1:0] force_rd_r;
  nnfc_pkg::stat_t                        stat_rd_r;
  logic                                   vld_rd_r;

  always_ff @(posedge clk) begin
    if (wr.force_en) begin
      force_mem[wr.addr] <= wr.entry.force_val;
    end
    if (wr.stat_en) begin
      stat_mem[wr.addr] <= wr.entry.stat;
    end
    force_rd_r <= force_mem[rd_addr];
    stat_rd_r  <= stat_mem[rd_addr];
  end

  // Status entries that were never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < nnfc_pkg::ACTUATORS; i++) begin
        stat_vld_r[i] <= 1'b0;
      end
      vld_rd_r <= 1'b0;
    end else begin
      if (wr.stat_en) begin
        stat_vld_r[wr.addr] <= 1'b1;
      end
      vld_rd_r <= stat_vld_r[rd_addr];
    end
  end

  always_comb begin
    rd_data.force_val = force_rd_r;
    rd_data.stat      = vld_rd_r ? stat_rd_r : '0;
  end

endmodule

// ===== src/nnfc_nb_mem.sv =====
module nnfc_nb_mem (
  input  logic                           clk,
  input  logic [nnfc_pkg::NB_ADDR_W-1:0] rd_addr,
  output logic [nnfc_pkg::NB_W-1:0]      rd_data,
  input  nnfc_pkg::nb_wr_t               wr
);

  logic [nnfc_pkg::NB_W-1:0] nb_mem [nnfc_pkg::ACTUATORS * (2 ** nnfc_pkg::NB_IDX_W)];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      nb_mem[wr.addr] <= wr.data;
    end
    rd_data <= nb_mem[rd_addr];
  end

endmodule

// ===== src/nnfc_seq.sv =====
module nnfc_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nnfc_pkg::in_item_t             in_item,
  input  logic [nnfc_pkg::LIMIT_W-1:0]   near_limit,
  output logic [nnfc_pkg::AIDX_W-1:0]    act_rd_addr,
  input  nnfc_pkg::act_entry_t           act_rd_data,
  output nnfc_pkg::act_wr_t              act_wr,
  output logic [nnfc_pkg::NB_ADDR_W-1:0] nb_rd_addr,
  input  logic [nnfc_pkg::NB_W-1:0]      nb_rd_data,
  output nnfc_pkg::nb_wr_t               nb_wr,
  input  logic                           out_free,
  output logic                           res_push,
  output nnfc_pkg::out_item_t            res
);

  nnfc_pkg::seq_state_t state_r, state_nxt;
  nnfc_pkg::in_item_t   item_r, item_nxt;
  nnfc_pkg::out_item_t  res_r, res_nxt;

  logic signed [nnfc_pkg::FORCE_BITS-1:0] own_force_r, own_force_nxt;
  logic [nnfc_pkg::CNTS_W-1:0]            own_cnt_r, own_cnt_nxt;
  logic [nnfc_pkg::CNTS_W-1:0]            j_r, j_nxt;
  logic                                   v1_r, v1_nxt;
  logic                                   v2_r, v2_nxt;
  logic signed [nnfc_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic signed [nnfc_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic [nnfc_pkg::LIM_PROD_W-1:0]        lim_r, lim_nxt;
  logic                                   any_r, any_nxt;

  logic                                   accept;
  logic [nnfc_pkg::AIDX_W-1:0]            act_idx;
  logic                                   in_range;
  logic                                   slot_ok;
  logic                                   nb_ok;
  logic                                   issue;
  logic                                   check_go;
  logic [nnfc_pkg::CNTS_W-1:0]            cnt_sat;
  logic signed [nnfc_pkg::DIFF_W-1:0]     diff;
  logic [nnfc_pkg::DIFF_W-1:0]            mag;
  logic                                   warn_calc;
  logic [nnfc_pkg::EXCESS_W-1:0]          excess_sat;

  assign in_stall = (state_r != nnfc_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign res      = res_r;

  assign act_idx  = nnfc_pkg::AIDX_W'(item_r.actuator);
  assign in_range = 32'(item_r.actuator) < nnfc_pkg::ACTUATORS;
  assign slot_ok  = 32'(item_r.slot) < nnfc_pkg::MAX_NEAR;
  assign nb_ok    = 32'(nb_rd_data) < nnfc_pkg::ACTUATORS;
  assign issue    = (state_r == nnfc_pkg::S_SUM) && (j_r < own_cnt_r);
  assign check_go = in_range && !act_rd_data.stat.disabled;
  assign cnt_sat  = (32'(item_r.count) > nnfc_pkg::MAX_NEAR) ?
                    nnfc_pkg::CNTS_W'(nnfc_pkg::MAX_NEAR) :
                    nnfc_pkg::CNTS_W'(item_r.count);

  assign act_rd_addr = (state_r == nnfc_pkg::S_SUM) ? nnfc_pkg::AIDX_W'(nb_rd_data) :
                       nnfc_pkg::AIDX_W'(in_item.actuator);
  assign nb_rd_addr  = {act_idx, j_r[nnfc_pkg::NB_IDX_W-1:0]};

  assign diff       = nnfc_pkg::DIFF_W'(prod_r) - nnfc_pkg::DIFF_W'(sum_r);
  assign mag        = diff[nnfc_pkg::DIFF_W-1] ? nnfc_pkg::DIFF_W'(-diff) :
                      nnfc_pkg::DIFF_W'(diff);
  assign warn_calc  = 64'(mag) > 64'(lim_r);
  assign excess_sat = (64'(mag) > nnfc_pkg::EXCESS_MAX) ?
                      nnfc_pkg::EXCESS_W'(nnfc_pkg::EXCESS_MAX) :
                      nnfc_pkg::EXCESS_W'(mag);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nnfc_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = nnfc_pkg::S_ENTRY;
        end
      end
      nnfc_pkg::S_ENTRY: begin
        if (item_r.command == nnfc_pkg::CMD_CHECK && check_go) begin
          state_nxt = nnfc_pkg::S_SUM;
        end else begin
          state_nxt = nnfc_pkg::S_DONE;
        end
      end
      nnfc_pkg::S_SUM: begin
        if (!issue && !v1_r && !v2_r) begin
          state_nxt = nnfc_pkg::S_MUL;
        end
      end
      nnfc_pkg::S_MUL: state_nxt = nnfc_pkg::S_CMP;
      nnfc_pkg::S_CMP: state_nxt = nnfc_pkg::S_DONE;
      nnfc_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = nnfc_pkg::S_IDLE;
        end
      end
      default: state_nxt = nnfc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = accept ? in_item : item_r;
    own_force_nxt = own_force_r;
    own_cnt_nxt   = own_cnt_r;
    j_nxt         = j_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    lim_nxt       = lim_r;
    any_nxt       = any_r;
    res_nxt       = res_r;
    act_wr        = '0;
    nb_wr         = '0;
    res_push      = 1'b0;
    act_wr.addr   = act_idx;
    nb_wr.addr    = {act_idx, nnfc_pkg::NB_IDX_W'(item_r.slot)};
    nb_wr.data    = item_r.neighbor;
    case (state_r)
      nnfc_pkg::S_ENTRY: begin
        res_nxt.actuator_res = item_r.actuator;
        res_nxt.warning      = in_range && act_rd_data.stat.warn;
        res_nxt.skipped      = 1'b0;
        res_nxt.excess       = '0;
        res_nxt.any_warning  = any_r;
        case (item_r.command)
          nnfc_pkg::CMD_FORCE: begin
            act_wr.force_en        = in_range;
            act_wr.entry.force_val = $signed(nnfc_pkg::FORCE_BITS'(item_r.force_req));
          end
          nnfc_pkg::CMD_NEIGHBOR: begin
            nb_wr.en = in_range && slot_ok;
          end
          nnfc_pkg::CMD_COUNT: begin
            act_wr.stat_en             = in_range;
            act_wr.entry.stat.count    = cnt_sat;
            act_wr.entry.stat.disabled = item_r.disabled;
            act_wr.entry.stat.warn     = act_rd_data.stat.warn;
          end
          nnfc_pkg::CMD_CHECK: begin
            any_nxt             = item_r.start_pass ? 1'b0 : any_r;
            res_nxt.any_warning = any_nxt;
            res_nxt.skipped     = !check_go;
            own_force_nxt       = act_rd_data.force_val;
            own_cnt_nxt         = act_rd_data.stat.count;
            j_nxt               = '0;
            sum_nxt             = '0;
          end
          default: ;
        endcase
      end
      nnfc_pkg::S_SUM: begin
        j_nxt  = issue ? j_r + 1'b1 : j_r;
        v1_nxt = issue;
        v2_nxt = v1_r && nb_ok;
        if (v2_r) begin
          sum_nxt = sum_r + nnfc_pkg::SUM_W'(act_rd_data.force_val);
        end
      end
      nnfc_pkg::S_MUL: begin
        prod_nxt = $signed({1'b0, own_cnt_r}) * own_force_r;
        lim_nxt  = own_cnt_r * near_limit;
      end
      nnfc_pkg::S_CMP: begin
        act_wr.stat_en             = 1'b1;
        act_wr.entry.stat.count    = own_cnt_r;
        act_wr.entry.stat.disabled = 1'b0;
        act_wr.entry.stat.warn     = warn_calc;
        any_nxt                    = any_r || warn_calc;
        res_nxt.warning            = warn_calc;
        res_nxt.skipped            = 1'b0;
        res_nxt.excess             = excess_sat;
        res_nxt.any_warning        = any_nxt;
      end
      nnfc_pkg::S_DONE: begin
        res_push = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnfc_pkg::S_IDLE;
      any_r   <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      any_r   <= any_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    own_force_r <= own_force_nxt;
    own_cnt_r   <= own_cnt_nxt;
    j_r         <= j_nxt;
    sum_r       <= sum_nxt;
    prod_r      <= prod_nxt;
    lim_r       <= lim_nxt;
    res_r       <= res_nxt;
  end

  a_accept_reads_entry: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == nnfc_pkg::S_ENTRY)
    else $error("accepted item did not move to the entry read");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nnfc_pkg::S_SUM |-> (j_r <= own_cnt_r &&
      32'(own_cnt_r) <= nnfc_pkg::MAX_NEAR))
    else $error("neighbour slot counter ran past the stored count");

  a_no_write_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nnfc_pkg::S_SUM |-> (!act_wr.force_en && !act_wr.stat_en && !nb_wr.en))
    else $error("store written while neighbour forces are being read");

  a_cmp_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nnfc_pkg::S_CMP |=> state_r == nnfc_pkg::S_DONE)
    else $error("compare step did not complete the item");

  a_push_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> state_r == nnfc_pkg::S_IDLE)
    else $error("result pushed without returning to idle");

endmodule

// ===== src/near_neighbor_force_check.sv =====
// Near-neighbour force check. Each item is a command: load a force, load one neighbour entry,
// load a neighbour count with the disabled mark, or check one actuator against the mean of its
// neighbours' forces; every item gives exactly one result item. Items are handled one at a
// time. A load, or a check of a disabled or out-of-range actuator, goes from the entry read
// straight to the result; a check of any other actuator also sums its neighbours' forces,
// since the neighbour table and the actuator store each have one read port and the neighbour
// forces are fetched through them one per cycle in a two-stage read pipeline, followed by a
// multiply step and a compare step. The result sits in an output register, so a waiting result
// does not hold up acceptance of the next item; that item then waits for the register to drain
// before it completes. The limit register is written through the cfg port, which is always
// ready, and must only be written while the block is idle.
module near_neighbor_force_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  nnfc_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output nnfc_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nnfc_pkg::LIMIT_W-1:0] cfg_data
);

  logic [nnfc_pkg::LIMIT_W-1:0]   near_limit_r;
  logic                           out_valid_r;
  nnfc_pkg::out_item_t            out_item_r;

  logic [nnfc_pkg::AIDX_W-1:0]    act_rd_addr;
  nnfc_pkg::act_entry_t           act_rd_data;
  nnfc_pkg::act_wr_t              act_wr;
  logic [nnfc_pkg::NB_ADDR_W-1:0] nb_rd_addr;
  logic [nnfc_pkg::NB_W-1:0]      nb_rd_data;
  nnfc_pkg::nb_wr_t               nb_wr;
  logic                           out_free;
  logic                           res_push;
  nnfc_pkg::out_item_t            res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      near_limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_item_r <= res;
    end
  end

  nnfc_act_mem u_act_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (act_rd_addr),
    .rd_data (act_rd_data),
    .wr      (act_wr)
  );

  nnfc_nb_mem u_nb_mem (
    .clk     (clk),
    .rd_addr (nb_rd_addr),
    .rd_data (nb_rd_data),
    .wr      (nb_wr)
  );

  nnfc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .near_limit  (near_limit_r),
    .act_rd_addr (act_rd_addr),
    .act_rd_data (act_rd_data),
    .act_wr      (act_wr),
    .nb_rd_addr  (nb_rd_addr),
    .nb_rd_data  (nb_rd_data),
    .nb_wr       (nb_wr),
    .out_free    (out_free),
    .res_push    (res_push),
    .res         (res)
  );

endmodule
